// ----- design/plis_pkg.sv -----
`default_nettype none
package plis_pkg;

    localparam int LABELS_DEFAULT = 256;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int OP_W = 2;
    localparam int LABEL_W = 8;
    localparam int GREY_W = 16;
    localparam int COUNT_W = 40;
    localparam int SUM_W = 64;
    localparam int SQUARE_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Work classes handed from the front to the back
    typedef enum logic [1:0] {
        K_ACC,
        K_READ,
        K_READ_ZERO,
        K_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [LABEL_W-1:0]        label;
        logic signed [GREY_W-1:0]  grey;
    } entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   square_sum;
    } stat_word_t;

    localparam int WORD_W = $bits(stat_word_t);

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_READ
    } back_state_t;

endpackage
`default_nettype wire

// ----- design/plis_ram.sv -----
`default_nettype none
module plis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- design/plis_front.sv -----
`default_nettype none
module plis_front #(
    parameter int LABELS = plis_pkg::LABELS_DEFAULT
) (
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [plis_pkg::OP_W-1:0]         s_op,
    input  wire logic [plis_pkg::LABEL_W-1:0]      s_label,
    input  wire logic signed [plis_pkg::GREY_W-1:0] s_grey,
    input  wire plis_pkg::back_status_t            status,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output plis_pkg::entry_t                       q_entry
);

    import plis_pkg::*;

    logic in_range;
    logic keep;

    assign in_range = 32'(s_label) < LABELS;
    assign s_ready  = !q_full && !status.clearing;

    always_comb begin
        keep = 1'b0;
        q_entry.kind  = K_ACC;
        q_entry.label = s_label;
        q_entry.grey  = s_grey;
        unique case (op_t'(s_op))
            OP_ACC: begin
                // drop voxels whose label has no entry
                keep = in_range;
                q_entry.kind = K_ACC;
            end
            OP_READ: begin
                keep = 1'b1;
                q_entry.kind = in_range ? K_READ : K_READ_ZERO;
            end
            OP_CLEAR: begin
                keep = 1'b1;
                q_entry.kind = K_CLEAR;
            end
            OP_NONE: begin
                keep = 1'b0;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = s_valid && s_ready && keep;

endmodule
`default_nettype wire

// ----- design/plis_queue.sv -----
`default_nettype none
module plis_queue #(
    parameter int DEPTH = plis_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire plis_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output plis_pkg::entry_t       head
);

    import plis_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ----- design/plis_back.sv -----
`default_nettype none
module plis_back #(
    parameter int LABELS = plis_pkg::LABELS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    input  wire plis_pkg::entry_t                   q_entry,
    output logic                                    q_pop,
    output plis_pkg::back_status_t                  status,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [plis_pkg::COUNT_W-1:0]            m_voxel_count,
    output logic signed [plis_pkg::SUM_W-1:0]       m_grey_sum,
    output logic [plis_pkg::SUM_W-1:0]              m_grey_square_sum
);

    import plis_pkg::*;

    localparam int ADDR_W = $clog2(LABELS);

    back_state_t               state_reg, state_next;
    logic [ADDR_W-1:0]         clr_idx_reg, clr_idx_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic signed [GREY_W-1:0]  grey_reg, grey_next;
    logic [SQUARE_W-1:0]       square_reg, square_next;
    logic                      zero_reg, zero_next;
    logic                      m_valid_reg, m_valid_next;
    stat_word_t                out_reg, out_next;

    logic signed [SQUARE_W-1:0] product;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    stat_word_t                 ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [WORD_W-1:0]          ram_rdata;
    stat_word_t                 cur;

    plis_ram #(
        .WIDTH(WORD_W),
        .DEPTH(LABELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur     = stat_word_t'(ram_rdata);
    assign product = q_entry.grey * q_entry.grey;

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        addr_next    = addr_reg;
        grey_next    = grey_reg;
        square_next  = square_reg;
        zero_next    = zero_reg;
        out_next     = out_reg;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = '0;
        ram_raddr    = ADDR_W'(q_entry.label);

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                if (clr_idx_reg == ADDR_W'(LABELS - 1)) begin
                    clr_idx_next = '0;
                    state_next   = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_entry.kind)
                        K_ACC: begin
                            q_pop       = 1'b1;
                            addr_next   = ADDR_W'(q_entry.label);
                            grey_next   = q_entry.grey;
                            square_next = SQUARE_W'(product);
                            state_next  = ST_UPDATE;
                        end
                        K_READ, K_READ_ZERO: begin
                            // hold the read until the output register is free
                            if (!m_valid_reg) begin
                                q_pop      = 1'b1;
                                zero_next  = q_entry.kind == K_READ_ZERO;
                                state_next = ST_READ;
                            end
                        end
                        K_CLEAR: begin
                            q_pop        = 1'b1;
                            clr_idx_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UPDATE: begin
                ram_we               = 1'b1;
                ram_wdata.count      = cur.count + 1'b1;
                ram_wdata.sum        = cur.sum + {{(SUM_W-GREY_W){grey_reg[GREY_W-1]}}, grey_reg};
                ram_wdata.square_sum = cur.square_sum + {{(SUM_W-SQUARE_W){1'b0}}, square_reg};
                state_next           = ST_IDLE;
            end
            ST_READ: begin
                out_next     = zero_reg ? '0 : cur;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        grey_reg   <= grey_next;
        square_reg <= square_next;
        zero_reg   <= zero_next;
        out_reg    <= out_next;
    end

    assign status.clearing   = state_reg == ST_CLEAR;
    assign m_valid           = m_valid_reg;
    assign m_voxel_count     = out_reg.count;
    assign m_grey_sum        = out_reg.sum;
    assign m_grey_square_sum = out_reg.square_sum;

endmodule
`default_nettype wire

// ----- design/per_label_intensity_statistics_core.sv -----
// Per-label intensity statistics: keeps a voxel count (40 bits), a grey sum and a sum of
// squared grey values (64 bits, wrapping) for each of LABELS labels in one RAM. op 0 adds a
// voxel, op 1 returns one label's accumulators as a single result, op 2 zeroes the store;
// labels at or above LABELS are ignored by accumulate and read back as zero, op 3 is
// dropped. Accepted transactions wait in a short queue ahead of the execution sequencer.
// An accumulate is a read-modify-write through the RAM's registered read port. A read
// waits until the result register is empty; it cannot start in the cycle in which the
// previous result is taken, and it waits longer while m_ready is low. A clear writes
// zero to every label in turn; after reset a clearing pass over the store runs first.
// While the store is being cleared s_ready is low.
`default_nettype none
module per_label_intensity_statistics_core #(
    parameter int LABELS      = plis_pkg::LABELS_DEFAULT,
    parameter int QUEUE_DEPTH = plis_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [plis_pkg::OP_W-1:0]          s_op,
    input  wire logic [plis_pkg::LABEL_W-1:0]       s_label,
    input  wire logic signed [plis_pkg::GREY_W-1:0] s_grey,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [plis_pkg::COUNT_W-1:0]            m_voxel_count,
    output logic signed [plis_pkg::SUM_W-1:0]       m_grey_sum,
    output logic [plis_pkg::SUM_W-1:0]              m_grey_square_sum
);

    import plis_pkg::*;

    back_status_t status;
    logic         q_full;
    logic         q_push;
    entry_t       push_entry;
    logic         q_pop;
    logic         q_valid;
    entry_t       head;

    plis_front #(
        .LABELS(LABELS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_label (s_label),
        .s_grey  (s_grey),
        .status  (status),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    plis_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (head)
    );

    plis_back #(
        .LABELS(LABELS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_entry           (head),
        .q_pop             (q_pop),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_voxel_count     (m_voxel_count),
        .m_grey_sum        (m_grey_sum),
        .m_grey_square_sum (m_grey_square_sum)
    );

endmodule
`default_nettype wire

// ----- design/plis_checker.sv -----
`default_nettype none
module plis_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [plis_pkg::COUNT_W-1:0]       m_voxel_count,
    input wire logic signed [plis_pkg::SUM_W-1:0]  m_grey_sum,
    input wire logic [plis_pkg::SUM_W-1:0]         m_grey_square_sum
);

    // Hold a stalled result steady
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_voxel_count) && $stable(m_grey_sum)
            && $stable(m_grey_square_sum))
        else $error("result changed while stalled");

    // g*g has the parity of g, so both sums share their low bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_grey_square_sum[0] == m_grey_sum[0])
        else $error("square sum parity disagrees with grey sum");

    // Drop any pending result on reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The store is cleared right after reset, so no transaction is taken then
    assert property (@(posedge aclk) !aresetn |=> !(s_valid && s_ready))
        else $error("transaction accepted during the clearing pass");

endmodule

bind per_label_intensity_statistics_core plis_checker u_plis_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_voxel_count     (m_voxel_count),
    .m_grey_sum        (m_grey_sum),
    .m_grey_square_sum (m_grey_square_sum)
);
`default_nettype wire

// ----- sim/tb_per_label_intensity_statistics_core.sv -----
`timescale 1ns / 100ps
module tb_per_label_intensity_statistics_core;
    import plis_pkg::*;

    localparam int LABEL_COUNT  = LABELS_DEFAULT;
    // a clear sweeps the whole store, so allow one full pass plus slack at the end
    localparam int DRAIN_CYCLES = LABEL_COUNT + 40;

    typedef struct {
        logic [COUNT_W-1:0]       count;
        logic signed [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]         square_sum;
    } label_stats_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op = OP_NONE;
    logic [LABEL_W-1:0]        s_label = '0;
    logic signed [GREY_W-1:0]  s_grey = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b1;
    logic [COUNT_W-1:0]        m_voxel_count;
    logic signed [SUM_W-1:0]   m_grey_sum;
    logic [SUM_W-1:0]          m_grey_square_sum;

    // running per-label statistics as the block should hold them
    logic [COUNT_W-1:0]        tally_count  [LABEL_COUNT];
    logic signed [SUM_W-1:0]   tally_sum    [LABEL_COUNT];
    logic [SUM_W-1:0]          tally_square [LABEL_COUNT];
    label_stats_t              expected_stats [$];
    logic [LABEL_W-1:0]        hot_labels [4];

    int mismatch_count = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    per_label_intensity_statistics_core #(
        .LABELS(LABEL_COUNT)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_label           (s_label),
        .s_grey            (s_grey),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_voxel_count     (m_voxel_count),
        .m_grey_sum        (m_grey_sum),
        .m_grey_square_sum (m_grey_square_sum)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void zero_tallies();
        for (int i = 0; i < LABEL_COUNT; i++) begin
            tally_count[i]  = '0;
            tally_sum[i]    = '0;
            tally_square[i] = '0;
        end
    endfunction

    function automatic void predict_item(op_t op, logic [LABEL_W-1:0] label,
                                         logic signed [GREY_W-1:0] grey);
        label_stats_t stats;
        longint g;
        g = grey;
        case (op)
            OP_ACC: begin
                if (label < LABEL_COUNT) begin
                    tally_count[label]  += 1;
                    tally_sum[label]    += SUM_W'(g);
                    tally_square[label] += SUM_W'(g * g);
                end
            end
            OP_READ: begin
                // labels past the store read back as zero
                if (label < LABEL_COUNT) begin
                    stats.count      = tally_count[label];
                    stats.sum        = tally_sum[label];
                    stats.square_sum = tally_square[label];
                end else begin
                    stats.count      = '0;
                    stats.sum        = '0;
                    stats.square_sum = '0;
                end
                expected_stats.push_back(stats);
            end
            OP_CLEAR: zero_tallies();
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    task automatic send_item(op_t op, logic [LABEL_W-1:0] label,
                             logic signed [GREY_W-1:0] grey);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 18);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_label <= label;
        s_grey  <= grey;
        do @(posedge aclk); while (!s_ready);
        predict_item(op, label, grey);
    endtask

    // hold the input side until every pending read has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_stats.size() != 0);
    endtask

    function automatic void shuffle_hot_labels();
        foreach (hot_labels[i])
            hot_labels[i] = LABEL_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            hot_labels[0] = 8'hFF;
        if ($urandom_range(0, 3) == 0)
            hot_labels[1] = 8'h00;
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label();
        if ($urandom_range(0, 9) < 7)
            return hot_labels[$urandom_range(0, 3)];
        return LABEL_W'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [GREY_W-1:0] pick_grey();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return $signed(GREY_W'($urandom_range(0, 16))) - 16'sd8;
            default: return GREY_W'($urandom);
        endcase
    endfunction

    task automatic send_random_item(bit allow_clear);
        int roll;
        op_t op;
        roll = $urandom_range(0, 99);
        if (allow_clear && roll < 2)
            op = OP_CLEAR;
        else if (roll < 6)
            op = OP_NONE;
        else if (roll < 30)
            op = OP_READ;
        else
            op = OP_ACC;
        send_item(op, pick_label(), pick_grey());
    endtask

    task automatic test_empty_reads();
        send_item(OP_READ, 8'h00, 16'sh0000);
        send_item(OP_READ, 8'hFF, 16'sh7FFF);
        send_item(OP_READ, 8'hAA, 16'sh8000);
    endtask

    task automatic test_extreme_voxels();
        send_item(OP_ACC, 8'h00, 16'sh8000);
        send_item(OP_ACC, 8'h00, 16'sh7FFF);
        send_item(OP_ACC, 8'hFF, 16'shFFFF);
        send_item(OP_ACC, 8'hFF, 16'sh0000);
        repeat (3) send_item(OP_ACC, 8'hAA, 16'sh8000);
        send_item(OP_ACC, 8'h55, 16'sh7FFF);
        // read straight behind the update of the same label
        send_item(OP_READ, 8'h55, 16'sh0000);
        send_item(OP_READ, 8'h00, 16'sh0000);
        send_item(OP_READ, 8'hFF, 16'shFFFF);
        send_item(OP_READ, 8'hAA, 16'sh5555);
    endtask

    task automatic test_unused_op();
        send_item(OP_NONE, 8'h00, 16'sh7FFF);
        send_item(OP_NONE, 8'hFF, 16'sh8000);
        send_item(OP_READ, 8'h00, 16'sh0000);
    endtask

    task automatic test_clear_store();
        send_item(OP_CLEAR, 8'h5A, 16'shA5A5);
        send_item(OP_READ, 8'h00, 16'sh0000);
        send_item(OP_READ, 8'hFF, 16'sh0000);
        send_item(OP_READ, 8'hAA, 16'sh0000);
        send_item(OP_ACC, 8'h00, 16'sh0005);
        send_item(OP_READ, 8'h00, 16'sh0000);
    endtask

    task automatic test_random_traffic(int items);
        for (int i = 0; i < items; i++) begin
            if (i % 60 == 0)
                shuffle_hot_labels();
            send_random_item(1'b1);
        end
    endtask

    task automatic test_drain_pause();
        logic [LABEL_W-1:0] label;
        for (int round = 0; round < 4; round++) begin
            label = LABEL_W'($urandom_range(0, 255));
            repeat (12) send_item(OP_ACC, label, pick_grey());
            send_item(OP_READ, label, pick_grey());
            hold_until_drained();
            send_item(OP_READ, label, pick_grey());
        end
    endtask

    task automatic test_steady_stream(int items);
        idle_on = 1'b0;
        shuffle_hot_labels();
        for (int i = 0; i < items; i++)
            send_random_item(i % 50 == 25);
    endtask

    // result side stalls in random bursts, except during the steady stream (idle_on low)
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        label_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                report_mismatch($sformatf("unexpected result transaction, count %0d",
                                          m_voxel_count));
            end else begin
                want = expected_stats.pop_front();
                if (m_voxel_count !== want.count)
                    report_mismatch($sformatf("voxel_count got %0d want %0d",
                                              m_voxel_count, want.count));
                if (m_grey_sum !== want.sum)
                    report_mismatch($sformatf("grey_sum got %0d want %0d",
                                              m_grey_sum, want.sum));
                if (m_grey_square_sum !== want.square_sum)
                    report_mismatch($sformatf("grey_square_sum got %0d want %0d",
                                              m_grey_square_sum, want.square_sum));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        zero_tallies();
        shuffle_hot_labels();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_reads();
        test_extreme_voxels();
        test_unused_op();
        test_clear_store();
        test_random_traffic(850);
        test_drain_pause();
        test_steady_stream(150);
        s_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/plis_pkg.sv
design/plis_ram.sv
design/plis_front.sv
design/plis_queue.sv
design/plis_back.sv
design/per_label_intensity_statistics_core.sv
design/plis_checker.sv
sim/tb_per_label_intensity_statistics_core.sv
